### src/sfb_pkg.sv
package sfb_pkg;

  localparam int NUM_BINS_DEF   = 64;
  localparam int MAX_X_MODE_DEF = 1024;
  localparam int MAX_Y_MODE_DEF = 1024;

  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 11;
  localparam int COEF_W    = 32;
  localparam int FLUX_W    = 64;
  localparam int BIN_IDX_W = 6;

  // k = mode * scale is IDX_W + CFG_W bits, k^2 one bit more than twice that
  localparam int A_W       = IDX_W + CFG_W;
  localparam int K2_W      = 2 * A_W + 1;
  localparam int ROOT_W    = A_W + 1;
  localparam int DIV_STEPS = FLUX_W + CFG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BW = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 32'h0001_0000;

  // multiplier sequence, issued in this order
  localparam int MOP_W   = 4;
  localparam int MUL_OPS = 10;
  localparam logic [MOP_W-1:0] MOP_AX  = 4'd0;
  localparam logic [MOP_W-1:0] MOP_BY  = 4'd1;
  localparam logic [MOP_W-1:0] MOP_AL2 = 4'd2;
  localparam logic [MOP_W-1:0] MOP_ALH = 4'd3;
  localparam logic [MOP_W-1:0] MOP_AH2 = 4'd4;
  localparam logic [MOP_W-1:0] MOP_BL2 = 4'd5;
  localparam logic [MOP_W-1:0] MOP_BLH = 4'd6;
  localparam logic [MOP_W-1:0] MOP_BH2 = 4'd7;
  localparam logic [MOP_W-1:0] MOP_WR  = 4'd8;
  localparam logic [MOP_W-1:0] MOP_WI  = 4'd9;

  typedef struct packed {
    logic                 load;
    logic                 mul_go;
    logic [MOP_W-1:0]     mul_sel;
    logic                 iter_init;
    logic                 sq_step;
    logic                 bs_step;
    logic                 dv_step;
    logic                 fin;
    logic                 rd_en;
    logic                 upd_wr;
    logic                 cl_load;
    logic                 frame_clr;
    logic                 total_clr;
    logic [BIN_IDX_W-1:0] addr;
  } sfb_cmd_t;

  typedef struct packed {
    logic                 mode_ok;
    logic                 k2_zero;
    logic                 over_range;
    logic [BIN_IDX_W-1:0] bin;
  } sfb_sts_t;

endpackage

### src/spectral_flux_binner.sv
// Shell-binned spectral flux. An accumulate transfer takes one Fourier mode and
// adds its enstrophy term Re(w*conj(adv)) and energy term (that over k^2) to
// every frame bin up to floor(k / bin_width); its length is set by the 96-step
// bit-serial divide of the energy term (the 44-step square root and the bin
// search run beside it) and the bin updates. Modes that are zero, out of range
// or past the last bin leave the frame as it was. A close transfer adds the
// frame into the running totals and sends one result per bin, waiting on a
// stalled output, then clears the frame. A clear transfer zeroes the totals.
// Registers are to be written only while idle; the block does not enforce it.
module spectral_flux_binner #(
  parameter int NUM_BINS   = sfb_pkg::NUM_BINS_DEF,
  parameter int MAX_X_MODE = sfb_pkg::MAX_X_MODE_DEF,
  parameter int MAX_Y_MODE = sfb_pkg::MAX_Y_MODE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sfb_pkg::CMD_W-1:0]           in_command,
  input  logic [sfb_pkg::IDX_W-1:0]           in_mode_x,
  input  logic signed [sfb_pkg::IDX_W-1:0]    in_mode_y,
  input  logic                                in_edge_mode,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_w_re,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_w_im,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_adv_re,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_adv_im,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfb_pkg::BIN_IDX_W-1:0]       out_bin_index,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_frame_energy,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_frame_enstrophy,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_energy_total,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_enstrophy_total,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfb_pkg::CFG_W-1:0]           cfg_data
);

  sfb_pkg::sfb_cmd_t cmd;
  sfb_pkg::sfb_sts_t sts;

  sfb_ctrl #(
    .NUM_BINS (NUM_BINS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  sfb_dp #(
    .NUM_BINS   (NUM_BINS),
    .MAX_X_MODE (MAX_X_MODE),
    .MAX_Y_MODE (MAX_Y_MODE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mode_x           (in_mode_x),
    .in_mode_y           (in_mode_y),
    .in_edge_mode        (in_edge_mode),
    .in_w_re             (in_w_re),
    .in_w_im             (in_w_im),
    .in_adv_re           (in_adv_re),
    .in_adv_im           (in_adv_im),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_bin_index       (out_bin_index),
    .out_frame_energy    (out_frame_energy),
    .out_frame_enstrophy (out_frame_enstrophy),
    .out_energy_total    (out_energy_total),
    .out_enstrophy_total (out_enstrophy_total),
    .out_last            (out_last)
  );

endmodule

### src/sfb_ctrl.sv
module sfb_ctrl #(
  parameter int NUM_BINS = sfb_pkg::NUM_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sfb_pkg::CMD_W-1:0]   in_command,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sfb_pkg::sfb_cmd_t           cmd,
  input  sfb_pkg::sfb_sts_t           sts
);

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int CNT_W = sfb_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MUL_END, S_CHK, S_ITER, S_FIN,
    S_UPD_RD, S_UPD_WR, S_CL_RD, S_CL_WR
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.addr      = cnt_r[sfb_pkg::BIN_IDX_W-1:0];
    cmd.mul_sel   = cnt_r[sfb_pkg::MOP_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            sfb_pkg::CMD_ACC: begin
              if (sts.mode_ok) begin
                cmd.load  = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_MUL;
              end
            end
            sfb_pkg::CMD_CLOSE: begin
              cnt_nxt   = '0;
              state_nxt = S_CL_RD;
            end
            sfb_pkg::CMD_CLEAR: cmd.total_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        if (cnt_r == CNT_W'(sfb_pkg::MUL_OPS - 1)) begin
          state_nxt = S_MUL_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // last product lands in its register here
      S_MUL_END: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.k2_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.iter_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_ITER;
        end
      end
      S_ITER: begin
        // root and divide run side by side, bin search follows the root
        cmd.dv_step = 1'b1;
        cmd.sq_step = cnt_r < CNT_W'(sfb_pkg::ROOT_W);
        cmd.bs_step = (cnt_r >= CNT_W'(sfb_pkg::ROOT_W)) &&
                      (cnt_r < CNT_W'(sfb_pkg::ROOT_W + BIN_W));
        if (cnt_r == CNT_W'(sfb_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (sts.over_range) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.fin   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (cnt_r[sfb_pkg::BIN_IDX_W-1:0] == sts.bin) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_UPD_RD;
        end
      end
      S_CL_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CL_WR;
      end
      S_CL_WR: begin
        if (!out_valid_r || !out_stall) begin
          cmd.cl_load   = 1'b1;
          out_valid_nxt = 1'b1;
          if (cnt_r == CNT_W'(NUM_BINS - 1)) begin
            cmd.frame_clr = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_CL_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cl_load |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  a_upd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_wr |-> (cnt_r[sfb_pkg::BIN_IDX_W-1:0] <= sts.bin))
    else $error("frame update past the mode's bin");

  a_close_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_clr |=> (state_r == S_IDLE) && out_valid_r)
    else $error("readout did not end on the last bin");

  a_iter_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER && cnt_r == CNT_W'(sfb_pkg::DIV_STEPS - 1)) |=> state_r == S_FIN)
    else $error("iteration did not finish");

endmodule

### src/sfb_dp.sv
module sfb_dp #(
  parameter int NUM_BINS   = sfb_pkg::NUM_BINS_DEF,
  parameter int MAX_X_MODE = sfb_pkg::MAX_X_MODE_DEF,
  parameter int MAX_Y_MODE = sfb_pkg::MAX_Y_MODE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sfb_pkg::IDX_W-1:0]           in_mode_x,
  input  logic signed [sfb_pkg::IDX_W-1:0]    in_mode_y,
  input  logic                                in_edge_mode,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_w_re,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_w_im,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_adv_re,
  input  logic signed [sfb_pkg::COEF_W-1:0]   in_adv_im,
  input  logic                                cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfb_pkg::CFG_W-1:0]           cfg_data,
  input  sfb_pkg::sfb_cmd_t                   cmd,
  output sfb_pkg::sfb_sts_t                   sts,
  output logic [sfb_pkg::BIN_IDX_W-1:0]       out_bin_index,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_frame_energy,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_frame_enstrophy,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_energy_total,
  output logic signed [sfb_pkg::FLUX_W-1:0]   out_enstrophy_total,
  output logic                                out_last
);

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int LIM_W  = sfb_pkg::CFG_W + $clog2(NUM_BINS + 1);
  localparam int BS_W   = sfb_pkg::CFG_W + BIN_W;
  localparam int FW     = sfb_pkg::FLUX_W;
  localparam int CW     = sfb_pkg::CFG_W;
  localparam int IW     = sfb_pkg::IDX_W;
  localparam int AW     = sfb_pkg::A_W;
  localparam int K2W    = sfb_pkg::K2_W;
  localparam int RW     = sfb_pkg::ROOT_W;
  localparam int DNW    = sfb_pkg::DIV_STEPS;
  localparam int SSW    = 2 * RW;
  localparam int SRW    = RW + 2;
  localparam logic signed [FW-1:0] FMAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] FMIN = {1'b1, {(FW-1){1'b0}}};

  function automatic logic signed [FW-1:0] sat_add(input logic signed [FW-1:0] a,
                                                   input logic signed [FW-1:0] b);
    logic signed [FW:0] s;
    s = {a[FW-1], a} + {b[FW-1], b};
    if (s[FW] != s[FW-1]) sat_add = s[FW] ? FMIN : FMAX;
    else sat_add = s[FW-1:0];
  endfunction

  function automatic logic [CW-1:0] mag32(input logic signed [CW-1:0] v);
    mag32 = v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // configuration
  logic [CW-1:0] kx_r, ky_r, bw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_r <= sfb_pkg::CFG_RESET;
      ky_r <= sfb_pkg::CFG_RESET;
      bw_r <= sfb_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfb_pkg::REG_KX: kx_r <= cfg_data;
        sfb_pkg::REG_KY: ky_r <= cfg_data;
        sfb_pkg::REG_BW: bw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // mode check on the live input
  logic [IW-1:0] amy_c;
  assign amy_c = in_mode_y[IW-1] ? IW'(-in_mode_y) : IW'(in_mode_y);

  assign sts.mode_ok = ((in_mode_x != '0) || (amy_c != '0)) &&
                       (32'(in_mode_x) <= 32'(MAX_X_MODE)) &&
                       (32'(amy_c) <= 32'(MAX_Y_MODE));

  logic [IW-1:0]            mx_r, amy_r;
  logic                     edge_r;
  logic signed [CW-1:0]     wr_r, wi_r, ar_r, ai_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mx_r   <= in_mode_x;
      amy_r  <= amy_c;
      edge_r <= in_edge_mode;
      wr_r   <= in_w_re;
      wi_r   <= in_w_im;
      ar_r   <= in_adv_re;
      ai_r   <= in_adv_im;
    end
  end

  // shared 32x32 multiplier; the product is registered in p_r before it is applied
  logic [AW-1:0]          a_r, b_r;
  logic [CW-1:0]          mul_a, mul_b;
  logic                   mul_neg;
  logic [FW-1:0]          p_r;
  logic                   pv_r, pneg_r;
  logic [sfb_pkg::MOP_W-1:0] pop_r;
  logic [K2W-1:0]         k2_r;
  logic signed [FW-1:0]   t1_r, t2_r;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (cmd.mul_sel)
      sfb_pkg::MOP_AX:  begin mul_a = CW'(mx_r);  mul_b = kx_r; end
      sfb_pkg::MOP_BY:  begin mul_a = CW'(amy_r); mul_b = ky_r; end
      sfb_pkg::MOP_AL2: begin mul_a = a_r[CW-1:0]; mul_b = a_r[CW-1:0]; end
      sfb_pkg::MOP_ALH: begin mul_a = a_r[CW-1:0]; mul_b = CW'(a_r[AW-1:CW]); end
      sfb_pkg::MOP_AH2: begin mul_a = CW'(a_r[AW-1:CW]); mul_b = CW'(a_r[AW-1:CW]); end
      sfb_pkg::MOP_BL2: begin mul_a = b_r[CW-1:0]; mul_b = b_r[CW-1:0]; end
      sfb_pkg::MOP_BLH: begin mul_a = b_r[CW-1:0]; mul_b = CW'(b_r[AW-1:CW]); end
      sfb_pkg::MOP_BH2: begin mul_a = CW'(b_r[AW-1:CW]); mul_b = CW'(b_r[AW-1:CW]); end
      sfb_pkg::MOP_WR: begin
        mul_a   = mag32(wr_r);
        mul_b   = mag32(ar_r);
        mul_neg = wr_r[CW-1] ^ ar_r[CW-1];
      end
      sfb_pkg::MOP_WI: begin
        mul_a   = mag32(wi_r);
        mul_b   = mag32(ai_r);
        mul_neg = wi_r[CW-1] ^ ai_r[CW-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= FW'(mul_a) * FW'(mul_b);
    pop_r  <= cmd.mul_sel;
    pneg_r <= mul_neg;
  end

  // cross term of a square counts twice
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k2_r <= '0;
    end else if (pv_r) begin
      unique case (pop_r)
        sfb_pkg::MOP_AX: a_r <= p_r[AW-1:0];
        sfb_pkg::MOP_BY: b_r <= p_r[AW-1:0];
        sfb_pkg::MOP_AL2, sfb_pkg::MOP_BL2: k2_r <= k2_r + K2W'(p_r);
        sfb_pkg::MOP_ALH, sfb_pkg::MOP_BLH: k2_r <= k2_r + (K2W'(p_r) << (CW + 1));
        sfb_pkg::MOP_AH2, sfb_pkg::MOP_BH2: k2_r <= k2_r + (K2W'(p_r) << (2 * CW));
        sfb_pkg::MOP_WR: t1_r <= pneg_r ? (~p_r + 1'b1) : p_r;
        sfb_pkg::MOP_WI: t2_r <= pneg_r ? (~p_r + 1'b1) : p_r;
        default: ;
      endcase
    end
  end

  assign sts.k2_zero = (k2_r == '0);

  // enstrophy term and its magnitude
  logic signed [FW-1:0] ens_c, ens_r;
  logic [FW-1:0]        mag_c;
  assign ens_c = sat_add(t1_r, t2_r);
  assign mag_c = ens_c[FW-1] ? (~ens_c + 1'b1) : ens_c;

  // restoring divider: (|ens| << 32) / k2
  logic [DNW-1:0] dv_num_r;
  logic [K2W-1:0] dv_rem_r;
  logic [FW-1:0]  dv_q_r;
  logic           dv_ovf_r;
  logic [K2W:0]   dv_sh, dv_d, dv_diff;
  logic           dv_ge;

  assign dv_sh   = {dv_rem_r, dv_num_r[DNW-1]};
  assign dv_d    = {1'b0, k2_r};
  assign dv_ge   = dv_sh >= dv_d;
  assign dv_diff = dv_sh - dv_d;

  // integer square root of k2, two bits a step
  logic [SSW-1:0] sq_src_r;
  logic [SRW-1:0] sq_rem_r;
  logic [RW-1:0]  sq_root_r;
  logic [SRW+1:0] sq_sh, sq_trial, sq_diff;
  logic           sq_ge;

  assign sq_sh    = {sq_rem_r, sq_src_r[SSW-1:SSW-2]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_diff  = sq_sh - sq_trial;

  // bin = largest b with b * bin_width <= isqrt(k2)
  logic [BIN_W-1:0] bs_q_r, bs_mask_r, bs_trial;
  logic [BS_W-1:0]  bs_prod;
  logic [LIM_W-1:0] lim;

  assign bs_trial = bs_q_r | bs_mask_r;
  assign bs_prod  = BS_W'(bs_trial) * BS_W'(bw_r);
  assign lim      = LIM_W'(bw_r) * LIM_W'(NUM_BINS);

  assign sts.over_range = RW'(lim) <= sq_root_r;
  assign sts.bin        = sfb_pkg::BIN_IDX_W'(bs_q_r);

  always_ff @(posedge clk) begin
    if (cmd.iter_init) begin
      ens_r     <= ens_c;
      dv_num_r  <= {mag_c, {CW{1'b0}}};
      dv_rem_r  <= '0;
      dv_q_r    <= '0;
      dv_ovf_r  <= 1'b0;
      sq_src_r  <= SSW'(k2_r);
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      bs_q_r    <= '0;
      bs_mask_r <= BIN_W'(1) << (BIN_W - 1);
    end else begin
      if (cmd.dv_step) begin
        dv_num_r <= dv_num_r << 1;
        dv_rem_r <= dv_ge ? dv_diff[K2W-1:0] : dv_sh[K2W-1:0];
        dv_q_r   <= {dv_q_r[FW-2:0], dv_ge};
        dv_ovf_r <= dv_ovf_r | dv_q_r[FW-1];
      end
      if (cmd.sq_step) begin
        sq_src_r  <= sq_src_r << 2;
        sq_rem_r  <= sq_ge ? sq_diff[SRW-1:0] : sq_sh[SRW-1:0];
        sq_root_r <= {sq_root_r[RW-2:0], sq_ge};
      end
      if (cmd.bs_step) begin
        if (RW'(bs_prod) <= sq_root_r) bs_q_r <= bs_trial;
        bs_mask_r <= bs_mask_r >> 1;
      end
    end
  end

  // energy term: saturate quotient, restore sign, weight
  logic [FW-1:0]        cap_c, qf_c;
  logic signed [FW-1:0] en_c, en_term_r, ens_term_r;

  assign cap_c = ens_r[FW-1] ? FMIN : FMAX;
  assign qf_c  = (dv_ovf_r || (dv_q_r > cap_c)) ? cap_c : dv_q_r;
  assign en_c  = ens_r[FW-1] ? (~qf_c + 1'b1) : qf_c;

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      en_term_r  <= edge_r ? en_c : sat_add(en_c, en_c);
      ens_term_r <= edge_r ? ens_r : sat_add(ens_r, ens_r);
    end
  end

  // bin stores; an entry without its valid bit reads as zero
  logic [2*FW-1:0]   frame_mem [NUM_BINS];
  logic [2*FW-1:0]   total_mem [NUM_BINS];
  logic [NUM_BINS-1:0] frame_vld_r, total_vld_r;
  logic [2*FW-1:0]   fr_rd_r, tt_rd_r;
  logic              fr_rv_r, tt_rv_r;
  logic [BIN_W-1:0]  addr;
  logic signed [FW-1:0] fe, fs, te, ts, tot_e, tot_s;

  assign addr  = cmd.addr[BIN_W-1:0];
  assign fe    = fr_rv_r ? fr_rd_r[2*FW-1:FW] : '0;
  assign fs    = fr_rv_r ? fr_rd_r[FW-1:0]    : '0;
  assign te    = tt_rv_r ? tt_rd_r[2*FW-1:FW] : '0;
  assign ts    = tt_rv_r ? tt_rd_r[FW-1:0]    : '0;
  assign tot_e = sat_add(te, fe);
  assign tot_s = sat_add(ts, fs);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      fr_rd_r <= frame_mem[addr];
      tt_rd_r <= total_mem[addr];
    end
    if (cmd.upd_wr) begin
      frame_mem[addr] <= {sat_add(fe, en_term_r), sat_add(fs, ens_term_r)};
    end
    if (cmd.cl_load) begin
      total_mem[addr] <= {tot_e, tot_s};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= '0;
      total_vld_r <= '0;
      fr_rv_r     <= 1'b0;
      tt_rv_r     <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        fr_rv_r <= frame_vld_r[addr];
        tt_rv_r <= total_vld_r[addr];
      end
      if (cmd.frame_clr) frame_vld_r <= '0;
      else if (cmd.upd_wr) frame_vld_r[addr] <= 1'b1;
      if (cmd.total_clr) total_vld_r <= '0;
      else if (cmd.cl_load) total_vld_r[addr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.cl_load) begin
      out_bin_index       <= cmd.addr;
      out_frame_energy    <= fe;
      out_frame_enstrophy <= fs;
      out_energy_total    <= tot_e;
      out_enstrophy_total <= tot_s;
      out_last            <= (cmd.addr == sfb_pkg::BIN_IDX_W'(NUM_BINS - 1));
    end
  end

endmodule
